/* sv/ldp_pkg.sv */
`timescale 1ns / 1ps

package ldp_pkg;

    localparam int KEY_DEPTH   = 1024;
    localparam int MOD_WIDTH   = 62;
    localparam int VAL_W       = 64;
    localparam int Q_W         = MOD_WIDTH + 1;
    localparam int KEY_AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int POS_W       = $clog2(KEY_DEPTH + 1) + 1;
    localparam int KEY_IDX_W   = 10;
    localparam int MODULUS_W   = 63;
    localparam int DIMENSION_W = 11;
    localparam int PHASE_W     = 62;
    localparam int CFG_IDX_W   = 2;

    // opcodes
    localparam logic OP_KEY_WRITE = 1'b0;
    localparam logic OP_ELEMENT   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 2'd1;

    typedef struct packed {
        logic                is_key;
        logic                key_we;
        logic [KEY_AW-1:0]   key_addr;
        logic                neg;
        logic [VAL_W-1:0]    magnitude;
    } ldp_item_t;

    // x + y mod q, both operands below q
    function automatic logic [MOD_WIDTH-1:0] add_mod(
        input logic [MOD_WIDTH-1:0] x,
        input logic [MOD_WIDTH-1:0] y,
        input logic [Q_W-1:0]       q
    );
        logic [Q_W-1:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= q) begin
            s = s - q;
        end
        return s[MOD_WIDTH-1:0];
    endfunction

endpackage

/* sv/ldp_ram.sv */
`timescale 1ns / 1ps

module ldp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ldp_front.sv */
`timescale 1ns / 1ps

module ldp_front import ldp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [KEY_IDX_W-1:0] s_key_index,
    input  logic [VAL_W-1:0]     s_element_value,
    output logic                 item_valid,
    output ldp_item_t            item,
    input  logic                 item_pop
);

    ldp_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    ldp_item_t  cls;
    logic       push, pop;

    // classify: key write in range, sign split of the operand
    always_comb begin
        cls.is_key    = (s_opcode == OP_KEY_WRITE);
        cls.key_we    = (s_opcode == OP_KEY_WRITE) && (int'(s_key_index) < KEY_DEPTH);
        cls.key_addr  = KEY_AW'(s_key_index);
        cls.neg       = s_element_value[VAL_W-1];
        cls.magnitude = s_element_value[VAL_W-1] ? (~s_element_value + 1'b1)
                                                 : s_element_value;
    end

    assign s_ready    = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = item_pop && item_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* sv/ldp_back.sv */
`timescale 1ns / 1ps

module ldp_back import ldp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [MODULUS_W-1:0]   modulus,
    input  logic [DIMENSION_W-1:0] dimension,
    input  logic                   item_valid,
    input  ldp_item_t              item,
    output logic                   item_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PHASE_W-1:0]     m_phase
);

    typedef enum logic [3:0] {
        S_IDLE, S_RED_V, S_FIX_V, S_RED_K, S_RED_A, S_MUL_D, S_MUL_A, S_ACC, S_OUT
    } state_t;

    localparam logic [5:0] RED_LAST = 6'(VAL_W - 1);
    localparam logic [5:0] MUL_LAST = 6'(MOD_WIDTH - 1);
    localparam logic [Q_W-1:0] Q_TOP = Q_W'(1) << MOD_WIDTH;

    state_t               state_reg;
    ldp_item_t            it_reg;
    logic [VAL_W-1:0]     src_reg;
    logic [MOD_WIDTH-1:0] rem_reg;
    logic [5:0]           cnt_reg;
    logic [MOD_WIDTH-1:0] v_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] mr_reg;
    logic [MOD_WIDTH-1:0] mb_reg;
    logic [MOD_WIDTH-1:0] res_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 m_valid_reg;
    logic [PHASE_W-1:0]   m_phase_reg;

    logic [Q_W-1:0]       q_eff;
    logic [POS_W-1:0]     n_eff;
    logic [Q_W-1:0]       t;
    logic [MOD_WIDTH-1:0] rem_next;
    logic [MOD_WIDTH-1:0] v_fix;
    logic [MOD_WIDTH-1:0] acc_sum;
    logic [MOD_WIDTH-1:0] key_rdata;
    logic                 ram_we;
    logic [KEY_AW-1:0]    key_raddr;

    always_comb begin
        if (modulus < MODULUS_W'(2)) begin
            q_eff = Q_W'(2);
        end else if (modulus > MODULUS_W'(Q_TOP)) begin
            q_eff = Q_TOP;
        end else begin
            q_eff = Q_W'(modulus);
        end
        if (dimension == '0) begin
            n_eff = POS_W'(1);
        end else if (int'(dimension) > KEY_DEPTH) begin
            n_eff = POS_W'(KEY_DEPTH);
        end else begin
            n_eff = POS_W'(dimension);
        end
    end

    // one restoring remainder step
    always_comb begin
        t = {rem_reg, src_reg[VAL_W-1]};
        if (t >= q_eff) begin
            t = t - q_eff;
        end
        rem_next = t[MOD_WIDTH-1:0];
    end

    assign v_fix     = (it_reg.neg && rem_reg != '0) ? MOD_WIDTH'(q_eff - Q_W'(rem_reg))
                                                     : rem_reg;
    assign acc_sum   = add_mod(acc_reg, mr_reg, q_eff);
    assign ram_we    = (state_reg == S_FIX_V) && it_reg.key_we;
    assign key_raddr = KEY_AW'(pos_reg - 1'b1);
    assign item_pop  = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_phase   = m_phase_reg;

    ldp_ram #(.WIDTH(MOD_WIDTH), .DEPTH(KEY_DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (it_reg.key_addr),
        .wdata (v_fix),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (item_valid) begin
                        it_reg    <= item;
                        src_reg   <= item.magnitude;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RED_V;
                    end
                end
                S_RED_V, S_RED_K, S_RED_A: begin
                    if (cnt_reg != RED_LAST) begin
                        rem_reg <= rem_next;
                        src_reg <= src_reg << 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        cnt_reg <= '0;
                        if (state_reg == S_RED_V) begin
                            rem_reg   <= rem_next;
                            state_reg <= S_FIX_V;
                        end else if (state_reg == S_RED_K) begin
                            mb_reg    <= rem_next;
                            src_reg   <= VAL_W'(acc_reg);
                            rem_reg   <= '0;
                            state_reg <= S_RED_A;
                        end else begin
                            acc_reg   <= rem_next;
                            mr_reg    <= '0;
                            state_reg <= S_MUL_D;
                        end
                    end
                end
                S_FIX_V: begin
                    v_reg <= v_fix;
                    if (it_reg.is_key) begin
                        state_reg <= S_IDLE;
                    end else if (pos_reg == '0) begin
                        acc_reg   <= v_fix;
                        pos_reg   <= POS_W'(1);
                        state_reg <= S_IDLE;
                    end else begin
                        src_reg   <= VAL_W'(key_rdata);
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RED_K;
                    end
                end
                S_MUL_D: begin
                    mr_reg    <= add_mod(mr_reg, mr_reg, q_eff);
                    state_reg <= S_MUL_A;
                end
                S_MUL_A: begin
                    if (mb_reg[MOD_WIDTH-1]) begin
                        mr_reg <= add_mod(mr_reg, v_reg, q_eff);
                    end
                    mb_reg  <= mb_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= (cnt_reg == MUL_LAST) ? S_ACC : S_MUL_D;
                end
                S_ACC: begin
                    if (pos_reg >= n_eff) begin
                        res_reg   <= acc_sum;
                        acc_reg   <= '0;
                        pos_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        acc_reg   <= acc_sum;
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_phase_reg <= PHASE_W'(res_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* sv/lwe_decryption_phase_top.sv */
`timescale 1ns / 1ps
// LWE decryption phase: b + sum(a_i * s_i) mod q.
// Input channel (s_valid/s_ready): opcode 0 writes key entry s_key_index with
// s_element_value reduced mod q; opcode 1 delivers the next ciphertext element,
// first b, then a_1..a_n with n = dimension. Every operand is a signed 64-bit
// value reduced into [0, q) by a bit-serial remainder unit.
// Result channel (m_valid/m_ready): one phase after the last mask element.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 modulus,
// index 1 dimension; other indexes are dropped. Write only while idle.
// Steps: a key write or b element takes one 64-step remainder pass, a mask
// element three such passes and a 62-bit shift-add modular multiply (double,
// then conditional add, per bit). A two-entry input queue and a result register
// let the front take transfers while the back works or the receiver stalls;
// the back keeps working on the next item while a result waits.
// Reset: modulus 2^32, dimension 1024, element position and accumulator
// zero, queue and result empty. Key store contents are undefined until written.
module lwe_decryption_phase_top import ldp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [KEY_IDX_W-1:0]   s_key_index,
    input  logic [VAL_W-1:0]       s_element_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PHASE_W-1:0]     m_phase,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MODULUS_W-1:0]   cfg_data
);

    logic [MODULUS_W-1:0]   modulus_reg;
    logic [DIMENSION_W-1:0] dimension_reg;
    logic                   item_valid;
    logic                   item_pop;
    ldp_item_t              item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= MODULUS_W'(64'h1_0000_0000);
            dimension_reg <= DIMENSION_W'(1024);
        end else if (cfg_valid) begin
            if (cfg_index == REG_MODULUS) begin
                modulus_reg <= cfg_data;
            end else if (cfg_index == REG_DIMENSION) begin
                dimension_reg <= cfg_data[DIMENSION_W-1:0];
            end
        end
    end

    // front: accept, classify, queue
    ldp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_key_index     (s_key_index),
        .s_element_value (s_element_value),
        .item_valid      (item_valid),
        .item            (item),
        .item_pop        (item_pop)
    );

    // back: reduce, key store, modular multiply-accumulate
    ldp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .modulus    (modulus_reg),
        .dimension  (dimension_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_phase    (m_phase)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb import ldp_pkg::*;;

    // index 2 is not a register; the block drops writes to it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd2;
    localparam int SETTLE_CYCLES = 1500;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_opcode;
    logic [KEY_IDX_W-1:0] s_key_index;
    logic [VAL_W-1:0]     s_element_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [PHASE_W-1:0]   m_phase;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MODULUS_W-1:0] cfg_data;

    lwe_decryption_phase_top i_dut (.*);

    // expected phases, oldest first
    logic [PHASE_W-1:0] phase_fifo[$];

    // mirror of the block's state
    logic [MODULUS_W-1:0]   mir_modulus;
    logic [DIMENSION_W-1:0] mir_dimension;
    logic [PHASE_W-1:0]     mir_keys[KEY_DEPTH];
    int                     mir_pos;
    logic [PHASE_W-1:0]     mir_acc;

    int errors;
    int items_sent;
    int phases_seen;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;

    // 125 MHz clock, 8 ns period
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #(64'd60_000_000);
        $display("lwe_decryption_phase_top regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic logic [Q_W-1:0] live_q();
        if (mir_modulus < 2) return Q_W'(2);
        if (mir_modulus > (63'd1 << MOD_WIDTH)) return 63'd1 << MOD_WIDTH;
        return mir_modulus;
    endfunction

    function automatic int live_dim();
        if (mir_dimension == 0) return 1;
        if (mir_dimension > KEY_DEPTH) return KEY_DEPTH;
        return int'(mir_dimension);
    endfunction

    // two's complement value folded into [0, q)
    function automatic logic [PHASE_W-1:0] fold_signed(logic [VAL_W-1:0] v,
                                                       logic [Q_W-1:0] q);
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] r;
        if (!v[VAL_W-1]) return PHASE_W'(v % q);
        mag = ~v + 64'd1;
        r = mag % q;
        return (r == 0) ? '0 : PHASE_W'(q - r);
    endfunction

    // one accepted input transfer; pushes the phase when a ciphertext closes
    function automatic void phase_step(logic op, logic [KEY_IDX_W-1:0] idx,
                                       logic [VAL_W-1:0] val);
        logic [Q_W-1:0]     q;
        logic [PHASE_W-1:0] v;
        logic [127:0]       prod;
        logic [127:0]       sum;
        q = live_q();
        v = fold_signed(val, q);
        if (op == OP_KEY_WRITE) begin
            mir_keys[idx] = v;
            return;
        end
        if (mir_pos == 0) begin
            mir_acc = v;
            mir_pos = 1;
            return;
        end
        prod = (128'(v) * 128'(mir_keys[mir_pos-1] % q)) % q;
        sum = (128'(mir_acc % q) + prod) % q;
        mir_acc = PHASE_W'(sum);
        if (mir_pos >= live_dim()) begin
            phase_fifo.push_back(mir_acc);
            mir_pos = 0;
            mir_acc = '0;
        end else begin
            mir_pos++;
        end
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    task automatic send_item(logic op, logic [KEY_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_opcode = op;
        s_key_index = idx;
        s_element_value = val;
        do @(posedge aclk); while (!s_ready);
        phase_step(op, idx, val);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MODULUS_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MODULUS) mir_modulus = data;
        else if (idx == REG_DIMENSION) mir_dimension = data[DIMENSION_W-1:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // registers change only once the back end has drained
    task automatic drain();
        while (phase_fifo.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'($urandom_range(100));
            5: return -64'($urandom_range(100));
            default: return r;
        endcase
    endfunction

    function automatic logic [MODULUS_W-1:0] rand_modulus();
        logic [VAL_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(11))
            0: return 63'($urandom_range(1));         // clamps up to 2
            1: return 63'd2;
            2: return 63'd1 << 32;
            3: return 63'd1 << MOD_WIDTH;
            4: return (63'd1 << MOD_WIDTH) + 63'd1;   // clamps down
            5: return '1;
            6, 7: return 63'($urandom_range(1000, 3));
            8: return r[MODULUS_W-1:0];
            default: return {1'b0, r[PHASE_W-1:0]};
        endcase
    endfunction

    // one setting: registers, key load, whole ciphertexts, maybe a dangling one
    task automatic run_phase(logic [MODULUS_W-1:0] q, logic [DIMENSION_W-1:0] dim,
                             int n_ct, bit leave_open);
        int n;
        drain();
        write_reg(REG_MODULUS, q);
        write_reg(REG_DIMENSION, dim);
        if ($urandom_range(3) == 0) write_reg(REG_NONE, '1);
        n = live_dim();
        for (int k = 0; k < n; k++) send_item(OP_KEY_WRITE, KEY_IDX_W'(k), rand_value());
        for (int c = 0; c < n_ct; c++) begin
            send_item(OP_ELEMENT, '0, rand_value());
            for (int e = 0; e < n; e++) begin
                // occasional key write in the middle of a ciphertext
                if ($urandom_range(15) == 0)
                    send_item(OP_KEY_WRITE, KEY_IDX_W'($urandom), rand_value());
                send_item(OP_ELEMENT, KEY_IDX_W'($urandom), rand_value());
            end
        end
        if (leave_open) begin
            send_item(OP_ELEMENT, '0, rand_value());
            repeat ($urandom_range(n - 1)) send_item(OP_ELEMENT, '0, rand_value());
        end
        phases_seen++;
    endtask

    // ---------------------------------------------------------------
    // receiver and checker
    // ---------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready = (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (phase_fifo.size() == 0) begin
                $error("phase transfer with none expected: got %h", m_phase);
                errors++;
            end else begin
                if (m_phase !== phase_fifo[0]) begin
                    $error("phase: expected %h actual %h", phase_fifo[0], m_phase);
                    errors++;
                end
                void'(phase_fifo.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // directed stimulus: dimension 2, modulus 2^32 after reset
    // ---------------------------------------------------------------
    typedef struct {
        logic                 op;
        logic [KEY_IDX_W-1:0] idx;
        logic [VAL_W-1:0]     val;
        bit                   has_exp;
        logic [PHASE_W-1:0]   exp_phase;
    } row_t;

    row_t dir_rows[$] = '{
        '{OP_KEY_WRITE, 10'd0,    64'd1,                  1'b0, '0},
        '{OP_KEY_WRITE, 10'd1,    '1,                     1'b0, '0},  // -1 -> q-1
        '{OP_KEY_WRITE, 10'd1023, 64'd5,                  1'b0, '0},  // top index
        // 5 + 3*1 + 1*(q-1) = 7
        '{OP_ELEMENT,   10'd0,    64'd5,                  1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd3,                  1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd1,                  1'b1, 62'd7},
        // most negative b folds to 0, most positive a1 to 2^32-1
        '{OP_ELEMENT,   10'd0,    64'h8000_0000_0000_0000, 1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd0,                  1'b1, 62'hFFFF_FFFF},
        // b = -1 wraps back to zero
        '{OP_ELEMENT,   10'd0,    '1,                     1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd1,                  1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd0,                  1'b1, 62'd0},
        // key rewrite mid ciphertext: 10 + 1*1 + 1*2 = 13
        '{OP_ELEMENT,   10'd0,    64'd10,                 1'b0, '0},
        '{OP_KEY_WRITE, 10'd1,    64'd2,                  1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd1,                  1'b0, '0},
        '{OP_ELEMENT,   10'd0,    64'd1,                  1'b1, 62'd13},
        // random-content rows, left to the predictor
        '{OP_ELEMENT,   10'h2AA,  64'h5A5A_1234_DEAD_BEEF, 1'b0, '0},
        '{OP_ELEMENT,   10'h155,  64'hA5A5_8765_0BAD_F00D, 1'b0, '0},
        '{OP_ELEMENT,   10'h3FF,  64'h0123_4567_89AB_CDEF, 1'b0, '0}
    };

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        errors = 0;
        items_sent = 0;
        phases_seen = 0;
        rx_hold_cycles = 0;
        tx_idle_pct = 21;
        rx_idle_pct = 79;
        s_valid = 1'b0;
        s_opcode = OP_KEY_WRITE;
        s_key_index = '0;
        s_element_value = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data = '0;
        mir_modulus = 63'd1 << 32;
        mir_dimension = 11'd1024;
        mir_pos = 0;
        mir_acc = '0;
        aresetn = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_reg(REG_DIMENSION, 11'd2);
        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val);
            // typed-in phase must agree with the predicted one, which was just queued
            if (dir_rows[r].has_exp &&
                (phase_fifo.size() == 0 || phase_fifo[$] !== dir_rows[r].exp_phase)) begin
                $error("phase: expected %h actual %h", dir_rows[r].exp_phase,
                       (phase_fifo.size() == 0) ? '0 : phase_fifo[$]);
                errors++;
            end
        end

        // long receiver stall with dimension 1: queue and result register fill up
        drain();
        rx_hold_cycles = 4000;
        run_phase(63'd97, 11'd1, 20, 1'b0);

        // widest modulus: clamps down to 2^62
        run_phase((63'd1 << MOD_WIDTH) + 63'd1, 11'd24, 2, 1'b0);

        // random phases, idle pattern swapped, then no idling at all
        while (items_sent < 1650) begin
            if (items_sent > 1250) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (items_sent > 750) begin
                tx_idle_pct = 79;
                rx_idle_pct = 21;
            end
            run_phase(rand_modulus(),
                      ($urandom_range(9) == 0) ? 11'd0 :
                      ($urandom_range(5) == 0) ? 11'($urandom_range(20, 9)) :
                                                 11'($urandom_range(8, 1)),
                      $urandom_range(4, 1), $urandom_range(3) == 0);
        end

        while (phase_fifo.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d input transfers over %0d register settings,", items_sent,
                 phases_seen);
        $display("incl. clamped modulus/dimension, open ciphertexts and a long output stall");
        if (errors == 0) begin
            $display("lwe_decryption_phase_top regression: pass");
        end else begin
            $display("lwe_decryption_phase_top regression: fail");
        end
        $finish;
    end

endmodule
